// ----- hdl/m3inv_pkg.sv -----
// shared widths, types and saturation helper for the 3x3 matrix inverse
package m3inv_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int NUM_ELEM   = 9;

  // internal widths
  localparam int PROD_W = 2 * DATA_WIDTH;
  localparam int COF_W  = 2 * DATA_WIDTH + 1;
  localparam int TERM_W = 3 * DATA_WIDTH;
  localparam int DET_W  = 3 * DATA_WIDTH + 1;
  localparam int MAG_W  = DET_W + 1;
  localparam int LW     = 4 * DATA_WIDTH + 2 * FRAC_BITS + 2;

  // stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = 8 * ((NUM_ELEM * DATA_WIDTH + 7) / 8);
  localparam int OUT_TDATA_W = 8 * (((NUM_ELEM + 1) * DATA_WIDTH + 7) / 8);

  // pipeline depths
  localparam int FRONT_LAT = 5;
  localparam int LANE_LAT  = DATA_WIDTH + 3;
  localparam int PIPE_LAT  = FRONT_LAT + LANE_LAT;

  typedef logic signed [DATA_WIDTH-1:0] elem_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [COF_W-1:0]      cof_t;
  typedef logic signed [TERM_W-1:0]     term_t;
  typedef logic signed [DET_W-1:0]      det_t;
  typedef logic [MAG_W-1:0]             mag_t;

  // apply sign to a rounded magnitude and clamp to the element range
  function automatic elem_t sat_round(input logic neg, input mag_t mag);
    mag_t  half;
    elem_t res;
    half = '0;
    half[DATA_WIDTH-1] = 1'b1;
    if (neg) begin
      if (mag > half) begin
        res = '0;
        res[DATA_WIDTH-1] = 1'b1;
      end else begin
        res = elem_t'(~mag[DATA_WIDTH-1:0] + 1'b1);
      end
    end else begin
      if (mag >= half) begin
        res = '1;
        res[DATA_WIDTH-1] = 1'b0;
      end else begin
        res = elem_t'(mag[DATA_WIDTH-1:0]);
      end
    end
    return res;
  endfunction

endpackage

// ----- hdl/m3inv_front.sv -----
// pair products, cofactors and determinant by the rule of Sarrus
module m3inv_front (
  input  logic                clk,
  input  logic                en,
  input  m3inv_pkg::elem_t    m [m3inv_pkg::NUM_ELEM],
  output m3inv_pkg::cof_t     cof [m3inv_pkg::NUM_ELEM],
  output m3inv_pkg::det_t     det
);
  import m3inv_pkg::*;

  // stage 1 registers
  prod_t p48, p57, p27, p18, p15, p24, p56, p38, p08;
  prod_t p26, p23, p05, p37, p46, p16, p07, p04, p13;
  elem_t c0, c6, c7, c8;

  // stage 2..4 registers
  cof_t  cof2 [NUM_ELEM];
  cof_t  cof3 [NUM_ELEM];
  cof_t  cof4 [NUM_ELEM];
  logic signed [2*DATA_WIDTH:0]   tlo [6];
  logic signed [2*DATA_WIDTH-1:0] thi [6];
  term_t tsum [6];
  det_t  sa, sb;

  prod_t tp [6];
  elem_t tm [6];

  // pair products used by the cofactors and the determinant
  always_ff @(posedge clk) begin
    if (en) begin
      p48 <= m[4] * m[8];  p57 <= m[5] * m[7];
      p27 <= m[2] * m[7];  p18 <= m[1] * m[8];
      p15 <= m[1] * m[5];  p24 <= m[2] * m[4];
      p56 <= m[5] * m[6];  p38 <= m[3] * m[8];
      p08 <= m[0] * m[8];  p26 <= m[2] * m[6];
      p23 <= m[2] * m[3];  p05 <= m[0] * m[5];
      p37 <= m[3] * m[7];  p46 <= m[4] * m[6];
      p16 <= m[1] * m[6];  p07 <= m[0] * m[7];
      p04 <= m[0] * m[4];  p13 <= m[1] * m[3];
      c0 <= m[0];
      c6 <= m[6];
      c7 <= m[7];
      c8 <= m[8];
    end
  end

  // terms of the determinant: first three add, last three subtract
  always_comb begin
    tp[0] = p04;  tm[0] = c8;
    tp[1] = p15;  tm[1] = c6;
    tp[2] = p23;  tm[2] = c7;
    tp[3] = p24;  tm[3] = c6;
    tp[4] = p13;  tm[4] = c8;
    tp[5] = p57;  tm[5] = c0;
  end

  // transposed cofactors and split triple products
  always_ff @(posedge clk) begin
    if (en) begin
      cof2[0] <= cof_t'(p48) - cof_t'(p57);
      cof2[1] <= cof_t'(p27) - cof_t'(p18);
      cof2[2] <= cof_t'(p15) - cof_t'(p24);
      cof2[3] <= cof_t'(p56) - cof_t'(p38);
      cof2[4] <= cof_t'(p08) - cof_t'(p26);
      cof2[5] <= cof_t'(p23) - cof_t'(p05);
      cof2[6] <= cof_t'(p37) - cof_t'(p46);
      cof2[7] <= cof_t'(p16) - cof_t'(p07);
      cof2[8] <= cof_t'(p04) - cof_t'(p13);
      for (int k = 0; k < 6; k++) begin
        tlo[k] <= $signed({1'b0, tp[k][DATA_WIDTH-1:0]}) * tm[k];
        thi[k] <= $signed(tp[k][PROD_W-1:DATA_WIDTH]) * tm[k];
      end
    end
  end

  // join partial products
  always_ff @(posedge clk) begin
    if (en) begin
      cof3 <= cof2;
      for (int k = 0; k < 6; k++) begin
        tsum[k] <= (term_t'(thi[k]) <<< DATA_WIDTH) + term_t'(tlo[k]);
      end
    end
  end

  // positive and negative diagonals
  always_ff @(posedge clk) begin
    if (en) begin
      cof4 <= cof3;
      sa <= det_t'(tsum[0]) + det_t'(tsum[1]) + det_t'(tsum[2]);
      sb <= det_t'(tsum[3]) + det_t'(tsum[4]) + det_t'(tsum[5]);
    end
  end

  // final determinant
  always_ff @(posedge clk) begin
    if (en) begin
      cof <= cof4;
      det <= sa - sb;
    end
  end

endmodule

// ----- hdl/m3inv_lane.sv -----
// one divider lane: rounded cofactor over determinant, a quotient bit per stage
module m3inv_lane (
  input  logic              clk,
  input  logic              en,
  input  m3inv_pkg::cof_t   cof,
  input  m3inv_pkg::det_t   det,
  output m3inv_pkg::elem_t  r
);
  import m3inv_pkg::*;

  logic [LW-1:0]         rem   [0:DATA_WIDTH];
  logic [LW-1:0]         dd    [0:DATA_WIDTH];
  logic [LW-1:0]         trial [0:DATA_WIDTH];
  logic                  ge    [0:DATA_WIDTH];
  logic [DATA_WIDTH:0]   q     [0:DATA_WIDTH+1];
  logic                  neg   [0:DATA_WIDTH+1];
  logic [COF_W-1:0]      an;
  logic [DET_W-1:0]      ad;

  // magnitudes
  always_comb begin
    an = cof[COF_W-1] ? COF_W'(-cof) : COF_W'(cof);
    ad = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
  end

  // setup: numerator 2|n| shifted up by 2*FRAC_BITS plus |d|, divisor 2|d|
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= (LW'(an) << (2 * FRAC_BITS + 1)) + LW'(ad);
      dd[0]  <= LW'(ad) << 1;
      neg[0] <= cof[COF_W-1] ^ det[DET_W-1];
      q[0]   <= '0;
    end
  end

  // restoring division, top stage detects overflow
  for (genvar s = 0; s <= DATA_WIDTH; s++) begin : g_stage
    localparam int B = DATA_WIDTH - s;

    always_comb begin
      trial[s] = dd[s] << B;
      ge[s]    = rem[s] >= trial[s];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q[s+1]   <= q[s] | ((DATA_WIDTH + 1)'(ge[s]) << B);
        neg[s+1] <= neg[s];
      end
    end

    if (s < DATA_WIDTH) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en) begin
          rem[s+1] <= ge[s] ? rem[s] - trial[s] : rem[s];
          dd[s+1]  <= dd[s];
        end
      end
    end
  end

  // sign and clamp
  always_ff @(posedge clk) begin
    if (en) begin
      r <= sat_round(neg[DATA_WIDTH+1], MAG_W'(q[DATA_WIDTH+1]));
    end
  end

endmodule

// ----- hdl/matrix3x3_inverse_cramer.sv -----
// top level: 3x3 matrix inverse by cofactors, nine divider lanes and merge
// datapath: products, cofactors and determinant first, then the bit-per-stage
//   divider lanes
// throughput: one matrix per cycle; the whole pipeline holds while a result
//   waits on m_tready
// reset: rst clears the valid line only; data registers are not reset
module matrix3x3_inverse_cramer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // m00 m01 m02 m10 m11 m12 m20 m21 m22, from the lowest bit up
  input  logic [m3inv_pkg::IN_TDATA_W-1:0]    s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // r00 r01 r02 r10 r11 r12 r20 r21 r22 determinant, from the lowest bit up
  output logic [m3inv_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // singular
  output logic                                m_tuser
);
  import m3inv_pkg::*;

  logic            en;
  logic [PIPE_LAT-1:0] vld;
  elem_t           m_in  [NUM_ELEM];
  cof_t            cof   [NUM_ELEM];
  elem_t           r     [NUM_ELEM];
  det_t            det;
  logic [DET_W-1:0] det_abs;
  mag_t            det_mag;
  elem_t           det_dl  [0:LANE_LAT-1];
  logic            sing_dl [0:LANE_LAT-1];

  // whole pipeline advances unless a word is held at the output
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[PIPE_LAT-1];

  // valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PIPE_LAT-2:0], s_tvalid};
    end
  end

  // unpack input word
  for (genvar i = 0; i < NUM_ELEM; i++) begin : g_unpack
    assign m_in[i] = s_tdata[i*DATA_WIDTH +: DATA_WIDTH];
  end

  m3inv_front u_front (
    .clk (clk),
    .en  (en),
    .m   (m_in),
    .cof (cof),
    .det (det)
  );

  // one divider lane per inverse element
  for (genvar i = 0; i < NUM_ELEM; i++) begin : g_lane
    m3inv_lane u_lane (
      .clk (clk),
      .en  (en),
      .cof (cof[i]),
      .det (det),
      .r   (r[i])
    );
  end

  // determinant rounded to the output scale
  always_comb begin
    det_abs = det[DET_W-1] ? DET_W'(-det) : DET_W'(det);
    det_mag = (MAG_W'(det_abs) + (MAG_W'(1) << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
  end

  // determinant and singular flag run alongside the lanes
  always_ff @(posedge clk) begin
    if (en) begin
      det_dl[0]  <= sat_round(det[DET_W-1], det_mag);
      sing_dl[0] <= (det == '0);
      for (int k = 1; k < LANE_LAT; k++) begin
        det_dl[k]  <= det_dl[k-1];
        sing_dl[k] <= sing_dl[k-1];
      end
    end
  end

  // merge lanes into the output word, zeros when singular
  always_comb begin
    m_tdata = '0;
    for (int i = 0; i < NUM_ELEM; i++) begin
      m_tdata[i*DATA_WIDTH +: DATA_WIDTH] = sing_dl[LANE_LAT-1] ? '0 : r[i];
    end
    m_tdata[NUM_ELEM*DATA_WIDTH +: DATA_WIDTH] = det_dl[LANE_LAT-1];
    m_tuser = sing_dl[LANE_LAT-1];
  end

endmodule

// ----- hdl/m3inv_chk.sv -----
// port checker for the matrix inverse, bound to the top level
module m3inv_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic [m3inv_pkg::IN_TDATA_W-1:0]  s_tdata,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [m3inv_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic                              m_tuser
);
  import m3inv_pkg::*;

  // no word leaves right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // input is taken whenever the output side can move
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not follow output side");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output word changed");

  // a singular matrix gives an all-zero word
  a_singular: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata == '0)
    else $error("singular result not zero");

endmodule

bind matrix3x3_inverse_cramer m3inv_chk u_m3inv_chk (.*);

// ----- test/matrix3x3_inverse_cramer_tb.sv -----
// testbench for the 3x3 fixed-point matrix inverse: random and directed matrices, scoreboard
module matrix3x3_inverse_cramer_tb;
  import m3inv_pkg::*;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    elem_t r[NUM_ELEM];
    elem_t det;
    logic  sing;
  } inv_res_t;

  typedef elem_t mat_t[NUM_ELEM];

  // expected inverses, worked out at input acceptance
  class inverse_scoreboard;
    inv_res_t pending_inv[$];
    int       errs;
    int       n_in;
    int       n_out;
    int       n_sing;

    function new();
      errs = 0;
      n_in = 0;
      n_out = 0;
      n_sing = 0;
    endfunction

    // round to nearest, ties away from zero
    function wide_t round_div(wide_t n, wide_t d);
      wide_t an;
      wide_t ad;
      wide_t q;
      an = (n < 0) ? -n : n;
      ad = (d < 0) ? -d : d;
      q = (2 * an + ad) / (2 * ad);
      return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function elem_t clamp(wide_t v);
      wide_t maxv;
      wide_t minv;
      maxv = wide_t'('h7fffffff);
      minv = -wide_t'('h80000000);
      if (v > maxv) return elem_t'(32'h7fffffff);
      if (v < minv) return elem_t'(32'h80000000);
      return elem_t'(v[DATA_WIDTH-1:0]);
    endfunction

    function wide_t cofac(wide_t a, wide_t b, wide_t c, wide_t d);
      return a * b - c * d;
    endfunction

    function void note_matrix(mat_t m);
      wide_t    e[NUM_ELEM];
      wide_t    c[NUM_ELEM];
      wide_t    dv;
      inv_res_t x;
      for (int i = 0; i < NUM_ELEM; i++) e[i] = m[i];
      dv = e[0] * e[4] * e[8] + e[1] * e[5] * e[6] + e[2] * e[3] * e[7]
         - e[2] * e[4] * e[6] - e[1] * e[3] * e[8] - e[5] * e[7] * e[0];
      n_in++;
      if (dv == 0) begin
        for (int i = 0; i < NUM_ELEM; i++) x.r[i] = '0;
        x.det = '0;
        x.sing = 1'b1;
      end else begin
        // transposed cofactors
        c[0] = cofac(e[4], e[8], e[5], e[7]);
        c[1] = cofac(e[2], e[7], e[1], e[8]);
        c[2] = cofac(e[1], e[5], e[2], e[4]);
        c[3] = cofac(e[5], e[6], e[3], e[8]);
        c[4] = cofac(e[0], e[8], e[2], e[6]);
        c[5] = cofac(e[2], e[3], e[0], e[5]);
        c[6] = cofac(e[3], e[7], e[4], e[6]);
        c[7] = cofac(e[1], e[6], e[0], e[7]);
        c[8] = cofac(e[0], e[4], e[1], e[3]);
        for (int i = 0; i < NUM_ELEM; i++)
          x.r[i] = clamp(round_div(c[i] <<< (2 * FRAC_BITS), dv));
        x.det = clamp(round_div(dv, wide_t'(1) <<< (2 * FRAC_BITS)));
        x.sing = 1'b0;
      end
      pending_inv.push_back(x);
    endfunction

    task report(string s);
      $display("mismatch at %0t: %s", $time, s);
      errs++;
    endtask

    task check_word(logic [OUT_TDATA_W-1:0] d, logic u);
      inv_res_t x;
      elem_t    got;
      n_out++;
      if (u) n_sing++;
      if (pending_inv.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        x = pending_inv.pop_front();
        for (int i = 0; i < NUM_ELEM; i++) begin
          got = d[i*DATA_WIDTH +: DATA_WIDTH];
          if (got !== x.r[i])
            report($sformatf("r%0d%0d got %h want %h", i / 3, i % 3, got, x.r[i]));
        end
        got = d[NUM_ELEM*DATA_WIDTH +: DATA_WIDTH];
        if (got !== x.det) report($sformatf("determinant got %h want %h", got, x.det));
        if (u !== x.sing) report($sformatf("singular got %b want %b", u, x.sing));
      end
    endtask
  endclass

  localparam int LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic m_tuser;

  int  tx_idle = 0;
  int  rx_idle = 0;
  logic hold_go = 1'b0;
  logic hold_on = 1'b0;
  int  cycles = 0;
  inverse_scoreboard sb = new();

  matrix3x3_inverse_cramer i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: check accepted words, then pick next ready
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser);
    m_tready <= !rst && !hold_on && ($urandom_range(99) >= rx_idle);
  end

  // long receiver hold-off, counted here
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  task send_matrix(mat_t m);
    if ($urandom_range(99) < tx_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < tx_idle) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    for (int i = 0; i < NUM_ELEM; i++) s_tdata[i*DATA_WIDTH +: DATA_WIDTH] <= m[i];
    do @(posedge clk); while (!s_tready);
    sb.note_matrix(m);
  endtask

  task drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_inv.size() != 0) @(posedge clk);
  endtask

  function elem_t pick_edge();
    case ($urandom_range(6))
      0: return elem_t'(32'h7fffffff);
      1: return elem_t'(32'h80000000);
      2: return '0;
      3: return elem_t'(1);
      4: return elem_t'(-1);
      5: return elem_t'(32'h00010000);
      default: return elem_t'(32'hffff0000);
    endcase
  endfunction

  // half moderate or diagonally boosted matrices, the rest singular, tiny, extreme or raw
  function mat_t rand_matrix();
    mat_t m;
    int   kind;
    kind = $urandom_range(9);
    for (int i = 0; i < NUM_ELEM; i++) begin
      case (kind)
        0, 1: m[i] = elem_t'($urandom);
        7: m[i] = elem_t'($urandom_range(0, 6)) - elem_t'(3);
        8: m[i] = pick_edge();
        default: m[i] = elem_t'($urandom_range(0, 1 << 20)) - elem_t'(1 << 19);
      endcase
    end
    if (kind == 6) begin
      // copy one row onto another, or one column onto another
      if ($urandom_range(1)) for (int j = 0; j < 3; j++) m[6 + j] = m[j];
      else for (int j = 0; j < 3; j++) m[3*j + 2] = m[3*j + 1];
    end
    if (kind == 9) begin
      for (int j = 0; j < 3; j++) m[4*j] = m[4*j] + elem_t'(32'h00080000);
    end
    return m;
  endfunction

  mat_t dm;

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: identity, zero, extremes, singular, tiny determinant
    dm = '{default: '0};
    dm[0] = 32'h00010000; dm[4] = 32'h00010000; dm[8] = 32'h00010000;
    send_matrix(dm);
    dm = '{default: '0};
    send_matrix(dm);
    dm = '{default: elem_t'(32'h7fffffff)};
    send_matrix(dm);
    dm = '{default: elem_t'(32'h80000000)};
    send_matrix(dm);
    dm = '{default: '0};
    dm[0] = 32'h7fffffff; dm[4] = 32'h7fffffff; dm[8] = 32'h7fffffff;
    send_matrix(dm);
    dm = '{default: '0};
    dm[0] = 32'h80000000; dm[4] = 32'h7fffffff; dm[8] = 32'h80000000;
    send_matrix(dm);
    dm = '{default: '0};
    dm[2] = 32'h80000000; dm[4] = 32'h80000000; dm[6] = 32'h80000000;
    send_matrix(dm);
    dm = '{default: '0};
    dm[0] = 1; dm[4] = 1; dm[8] = 1;
    send_matrix(dm);
    dm = '{default: '0};
    dm[0] = -1; dm[4] = 1; dm[8] = 1; dm[1] = 1;
    send_matrix(dm);
    dm = '{1, 2, 3, 4, 5, 6, 7, 8, 9};
    send_matrix(dm);
    dm = '{32'h00020000, 0, 0, 0, 32'h00040000, 0, 0, 0, 32'hfff80000};
    send_matrix(dm);
    dm = '{32'h00008000, 32'h00003000, 0, 32'hffff0000, 32'h00018000, 32'h7fffffff,
           0, 32'h80000000, 32'h00000003};
    send_matrix(dm);
    dm = '{default: elem_t'(32'h00010000)};
    send_matrix(dm);
    dm = '{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
           32'h80000000, 32'h7fffffff, 32'h80000000, 32'h00000001};
    send_matrix(dm);
    drain_results();

    // sender sparse-ish, receiver mostly stalled
    tx_idle = 16; rx_idle = 81;
    for (int k = 0; k < 250; k++) send_matrix(rand_matrix());

    // long receiver hold-off while words keep coming
    tx_idle = 0; rx_idle = 0;
    hold_go = 1'b1;
    for (int k = 0; k < 100; k++) send_matrix(rand_matrix());
    drain_results();

    // the other way round
    tx_idle = 81; rx_idle = 16;
    for (int k = 0; k < 200; k++) send_matrix(rand_matrix());

    // full rate both ways
    tx_idle = 0; rx_idle = 0;
    for (int k = 0; k < 350; k++) send_matrix(rand_matrix());

    drain_results();
    repeat (60) @(posedge clk);
    $display("%0d matrices in, %0d inverses out (%0d singular), stalls on both sides",
             sb.n_in, sb.n_out, sb.n_sing);
    if (sb.pending_inv.size() != 0) sb.report("expected words left over");
    if (sb.errs == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/m3inv_pkg.sv
hdl/m3inv_front.sv
hdl/m3inv_lane.sv
hdl/matrix3x3_inverse_cramer.sv
hdl/m3inv_chk.sv
test/matrix3x3_inverse_cramer_tb.sv
